// ===== src/tmtw_pkg.sv =====
package tmtw_pkg;

   // fixed field widths
   localparam int ACT_W     = 2;
   localparam int CHAR_W    = 8;
   localparam int IDX_W     = 11;
   localparam int ROW_OUT_W = 5;
   localparam int COL_OUT_W = 7;
   localparam int POS_OUT_W = 11;
   localparam int CELL_W    = 16;
   localparam int REQ_W     = 24;
   localparam int RSP_W     = 40;

   // actions
   localparam logic [ACT_W-1:0] ACT_PUT   = 2'd0;
   localparam logic [ACT_W-1:0] ACT_BS    = 2'd1;
   localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;
   localparam logic [ACT_W-1:0] ACT_READ  = 2'd3;

   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] ATTR_RST = 8'h07;

   // datapath operations
   localparam logic [3:0] OP_NONE   = 4'd0;
   localparam logic [3:0] OP_LOAD   = 4'd1;
   localparam logic [3:0] OP_PUT    = 4'd2;
   localparam logic [3:0] OP_LF     = 4'd3;
   localparam logic [3:0] OP_CR     = 4'd4;
   localparam logic [3:0] OP_BS     = 4'd5;
   localparam logic [3:0] OP_RD     = 4'd6;
   localparam logic [3:0] OP_CLR    = 4'd7;
   localparam logic [3:0] OP_COPY   = 4'd8;
   localparam logic [3:0] OP_FILL   = 4'd9;
   localparam logic [3:0] OP_RESULT = 4'd10;

   typedef struct packed {
      logic [3:0] op;
      logic       fill_init;   // fill with the reset cell instead of a blank
   } cmd_type;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic             is_lf;
      logic             is_cr;
      logic             at_origin;
      logic             need_scroll;
      logic             copy_last;
      logic             fill_last;
      logic             rsp_busy;
   } sts_type;

endpackage

// ===== src/tmtw_ram.sv =====
module tmtw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== src/tmtw_ctrl.sv =====
module tmtw_ctrl
   import tmtw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [2:0] S_INIT = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_EXEC = 3'd2;
   localparam logic [2:0] S_COPY = 3'd3;
   localparam logic [2:0] S_FILL = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      cmd.op        = OP_NONE;
      cmd.fill_init = 1'b0;
      req_tready    = 1'b0;
      case (state_ff)
         S_INIT: begin
            cmd.op        = OP_FILL;
            cmd.fill_init = 1'b1;
            if (sts.fill_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = OP_LOAD;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_DONE;
            case (sts.action)
               ACT_PUT: begin
                  if (sts.is_lf)      cmd.op = OP_LF;
                  else if (sts.is_cr) cmd.op = OP_CR;
                  else                cmd.op = OP_PUT;
                  if (sts.need_scroll) state_in = S_COPY;
               end
               ACT_BS: begin
                  if (!sts.at_origin) cmd.op = OP_BS;
               end
               ACT_CLEAR: begin
                  cmd.op   = OP_CLR;
                  state_in = S_FILL;
               end
               ACT_READ: cmd.op = OP_RD;
               default: cmd.op = OP_NONE;
            endcase
         end
         S_COPY: begin
            cmd.op = OP_COPY;
            if (sts.copy_last) state_in = S_FILL;
         end
         S_FILL: begin
            cmd.op = OP_FILL;
            if (sts.fill_last) state_in = S_DONE;
         end
         S_DONE: begin
            if (!sts.rsp_busy) begin
               cmd.op   = OP_RESULT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/tmtw_dp.sv =====
module tmtw_dp
   import tmtw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output sts_type              sts,
   input  logic [ACT_W-1:0]     req_action,
   input  logic [CHAR_W-1:0]    req_char_code,
   input  logic [IDX_W-1:0]     req_cell_index,
   input  logic                 csr_wr_en,
   input  logic [CHAR_W-1:0]    csr_wr_data,
   input  logic                 rsp_tready,
   output logic                 rsp_tvalid,
   output logic [ROW_OUT_W-1:0] rsp_cursor_row,
   output logic [COL_OUT_W-1:0] rsp_cursor_col,
   output logic [POS_OUT_W-1:0] rsp_cursor_pos,
   output logic [CELL_W-1:0]    rsp_cell_data,
   output logic                 rsp_scrolled
);

   localparam int CELLS  = ROWS * COLUMNS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int RW     = (ROW_W > ROW_OUT_W) ? ROW_W : ROW_OUT_W;
   localparam int CW     = (COL_W > COL_OUT_W) ? COL_W : COL_OUT_W;
   localparam int PW     = (ADDR_W > POS_OUT_W) ? ADDR_W : POS_OUT_W;
   localparam int IW     = (ADDR_W + 1 > IDX_W) ? ADDR_W + 1 : IDX_W;

   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [CHAR_W-1:0] attr_ff, attr_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic [ACT_W-1:0]  act_ff, act_in;
   logic [CHAR_W-1:0] chr_ff, chr_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              scr_ff, scr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ROW_OUT_W-1:0] rsp_row_ff, rsp_row_in;
   logic [COL_OUT_W-1:0] rsp_col_ff, rsp_col_in;
   logic [POS_OUT_W-1:0] rsp_pos_ff, rsp_pos_in;
   logic [CELL_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                 rsp_scr_ff, rsp_scr_in;

   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr, pos;
   logic [CELL_W-1:0] wr_data, rd_data, blank;
   logic              last_row, last_col;
   logic [IW-1:0]     idx_wide;
   logic              idx_ok;
   logic [RW-1:0]     row_wide;
   logic [CW-1:0]     col_wide;
   logic [PW-1:0]     pos_wide;

   assign pos      = ADDR_W'(row_ff) * ADDR_W'(COLUMNS) + ADDR_W'(col_ff);
   assign last_row = (row_ff == ROW_W'(ROWS - 1));
   assign last_col = (col_ff == COL_W'(COLUMNS - 1));
   assign blank    = {attr_ff, CH_SPACE};
   assign idx_wide = IW'(idx_ff);
   assign idx_ok   = (idx_wide < IW'(CELLS));
   assign row_wide = RW'(row_ff);
   assign col_wide = CW'(col_ff);
   assign pos_wide = PW'(pos);

   assign sts.action      = act_ff;
   assign sts.is_lf       = (chr_ff == CH_LF);
   assign sts.is_cr       = (chr_ff == CH_CR);
   assign sts.at_origin   = (row_ff == '0) && (col_ff == '0);
   // line feed, or a printable char in the last column, on the last row
   assign sts.need_scroll = last_row && (act_ff == ACT_PUT) &&
                            ((chr_ff == CH_LF) || ((chr_ff != CH_CR) && last_col));
   assign sts.copy_last   = (cnt_ff == ADDR_W'(CELLS - COLUMNS - 1));
   assign sts.fill_last   = (cnt_ff == ADDR_W'(CELLS - 1));
   assign sts.rsp_busy    = rsp_valid_ff && !rsp_tready;

   // cell store port control
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pos;
      wr_data = {attr_ff, chr_ff};
      rd_en   = 1'b0;
      rd_addr = ADDR_W'(COLUMNS);
      case (cmd.op)
         OP_PUT: begin
            wr_en = 1'b1;
            rd_en = sts.need_scroll;
         end
         OP_LF: rd_en = sts.need_scroll;
         OP_BS: begin
            wr_en   = 1'b1;
            wr_addr = pos - ADDR_W'(1);
            wr_data = blank;
         end
         OP_RD: begin
            rd_en   = 1'b1;
            rd_addr = idx_wide[ADDR_W-1:0];
         end
         OP_COPY: begin
            // read runs one row ahead of the write
            wr_en   = 1'b1;
            wr_addr = cnt_ff;
            wr_data = rd_data;
            rd_en   = !sts.copy_last;
            rd_addr = cnt_ff + ADDR_W'(COLUMNS + 1);
         end
         OP_FILL: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff;
            wr_data = cmd.fill_init ? {ATTR_RST, CH_SPACE} : blank;
         end
         default: wr_en = 1'b0;
      endcase
   end

   always_comb begin
      row_in       = row_ff;
      col_in       = col_ff;
      attr_in      = csr_wr_en ? csr_wr_data : attr_ff;
      cnt_in       = cnt_ff;
      act_in       = act_ff;
      chr_in       = chr_ff;
      idx_in       = idx_ff;
      scr_in       = scr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_scr_in   = rsp_scr_ff;
      case (cmd.op)
         OP_LOAD: begin
            act_in = req_action;
            chr_in = req_char_code;
            idx_in = req_cell_index;
            scr_in = 1'b0;
         end
         OP_PUT, OP_LF: begin
            if (cmd.op == OP_PUT && !last_col) begin
               col_in = col_ff + COL_W'(1);
            end else begin
               col_in = '0;
               if (!last_row) row_in = row_ff + ROW_W'(1);
            end
            if (sts.need_scroll) begin
               cnt_in = '0;
               scr_in = 1'b1;
            end
         end
         OP_CR: col_in = '0;
         OP_BS: begin
            if (col_ff == '0) begin
               row_in = row_ff - ROW_W'(1);
               col_in = COL_W'(COLUMNS - 1);
            end else begin
               col_in = col_ff - COL_W'(1);
            end
         end
         OP_CLR: begin
            row_in = '0;
            col_in = '0;
            cnt_in = '0;
         end
         OP_COPY, OP_FILL: begin
            if (!sts.fill_last) cnt_in = cnt_ff + ADDR_W'(1);
            else                cnt_in = '0;
         end
         OP_RESULT: begin
            rsp_valid_in = 1'b1;
            rsp_row_in   = row_wide[ROW_OUT_W-1:0];
            rsp_col_in   = col_wide[COL_OUT_W-1:0];
            rsp_pos_in   = pos_wide[POS_OUT_W-1:0];
            rsp_data_in  = (act_ff == ACT_READ && idx_ok) ? rd_data : '0;
            rsp_scr_in   = scr_ff;
         end
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         col_ff       <= '0;
         attr_ff      <= ATTR_RST;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_ff       <= row_in;
         col_ff       <= col_in;
         attr_ff      <= attr_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      chr_ff      <= chr_in;
      idx_ff      <= idx_in;
      scr_ff      <= scr_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_data_ff <= rsp_data_in;
      rsp_scr_ff  <= rsp_scr_in;
   end

   tmtw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_cells (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_pos = rsp_pos_ff;
   assign rsp_cell_data  = rsp_data_ff;
   assign rsp_scrolled   = rsp_scr_ff;

endmodule

// ===== src/text_mode_terminal_writer_core.sv =====
// Channel   Dir  Handshake              Payload
// req       in   req_tvalid/req_tready  action, char_code, cell_index
// rsp       out  rsp_tvalid/rsp_tready  cursor_row, cursor_col, cursor_pos, cell_data, scrolled
// csr       in   csr_wr_en              text_attribute
//
// Put, line feed, carriage return, backspace and read each pass through accept,
// execute and result load; the result register lets the next item in
// while the last result waits.
// A scroll adds a row copy then a bottom row fill through the single write
// port of the cell RAM; clear adds a fill of every cell likewise.
// After reset a clearing pass over every cell holds req_tready low.
// A stalled result holds the next item in its result load step until rsp drains.
module text_mode_terminal_writer_core
   import tmtw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // action[1:0], char_code[9:2], cell_index[20:10], zero[23:21]
   input  logic [REQ_W-1:0]  req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // cursor_row[4:0], cursor_col[11:5], cursor_pos[22:12], cell_data[38:23],
   // scrolled[39]
   output logic [RSP_W-1:0]  rsp_tdata,
   input  logic              csr_wr_en,
   input  logic [CHAR_W-1:0] csr_wr_data
);

   cmd_type cmd;
   sts_type sts;

   logic [ROW_OUT_W-1:0] cursor_row;
   logic [COL_OUT_W-1:0] cursor_col;
   logic [POS_OUT_W-1:0] cursor_pos;
   logic [CELL_W-1:0]    cell_data;
   logic                 scrolled;

   tmtw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   tmtw_dp #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_action     (req_tdata[1:0]),
      .req_char_code  (req_tdata[9:2]),
      .req_cell_index (req_tdata[20:10]),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_cursor_row (cursor_row),
      .rsp_cursor_col (cursor_col),
      .rsp_cursor_pos (cursor_pos),
      .rsp_cell_data  (cell_data),
      .rsp_scrolled   (scrolled)
   );

   assign rsp_tdata = {scrolled, cell_data, cursor_pos, cursor_col, cursor_row};

endmodule
